// ===== hw/rtl/operator_token_scanner_assert.svh =====
// ----------------------------------------------------------------------------
// Operator token scanner assertion macros
// Shared property forms used by the scanner's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef OPERATOR_TOKEN_SCANNER_ASSERT_SVH
`define OPERATOR_TOKEN_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// Operator token scanner package
// Token and prefix codes, result records and the prefix transition functions.
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int START_WIDTH  = 32;

    typedef logic [OFFSET_WIDTH-1:0] offset_t;

    typedef enum logic [5:0] {
        TK_NL, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_LBRACE, TK_RBRACE,
        TK_TILDE, TK_AT, TK_DOLLAR, TK_COMMA, TK_SEMI, TK_COLON,
        TK_ASSIGN, TK_EQ, TK_SLASH, TK_SLASH_EQ, TK_PCT, TK_PCT_EQ, TK_BANG, TK_NE,
        TK_DOT, TK_DOT2, TK_DOT2_EQ, TK_AMP, TK_AMP_EQ, TK_AMP2,
        TK_BAR, TK_BAR_EQ, TK_BAR2,
        TK_PLUS, TK_PLUS_EQ, TK_PLUS_PCT, TK_PLUS_PCT_EQ, TK_PLUS_BAR, TK_PLUS_BAR_EQ,
        TK_MINUS, TK_MINUS_EQ, TK_MINUS_PCT, TK_MINUS_PCT_EQ, TK_MINUS_BAR,
        TK_MINUS_BAR_EQ,
        TK_STAR, TK_STAR_EQ, TK_STAR_PCT, TK_STAR_PCT_EQ, TK_STAR_BAR, TK_STAR_BAR_EQ,
        TK_LT, TK_LE, TK_SHL, TK_SHL_EQ, TK_SHL_BAR, TK_SHL_BAR_EQ,
        TK_GT, TK_GE, TK_SHR, TK_SHR_EQ, TK_SHR_BAR, TK_SHR_BAR_EQ
    } token_t;

    typedef enum logic [4:0] {
        PFX_NONE, PFX_EQ, PFX_SLASH, PFX_PCT, PFX_BANG, PFX_DOT, PFX_DOT2,
        PFX_AMP, PFX_BAR,
        PFX_PLUS, PFX_PLUS_PCT, PFX_PLUS_BAR,
        PFX_MINUS, PFX_MINUS_PCT, PFX_MINUS_BAR,
        PFX_STAR, PFX_STAR_PCT, PFX_STAR_BAR,
        PFX_LT, PFX_LT2, PFX_LT2_BAR,
        PFX_GT, PFX_GT2, PFX_GT2_BAR
    } prefix_t;

    typedef enum logic [1:0] {
        ACT_MISS,
        ACT_TOKEN,
        ACT_GO,
        ACT_SKIP
    } act_t;

    typedef struct packed {
        act_t    act;
        token_t  tok;
        prefix_t pfx;
    } move_t;

    typedef struct packed {
        token_t                 code;
        logic                   bad;
        logic [START_WIDTH-1:0] at;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } record_t;

    localparam move_t MISS_MOVE = '{ACT_MISS, TK_NL, PFX_NONE};
    localparam move_t SKIP_MOVE = '{ACT_SKIP, TK_NL, PFX_NONE};

    function automatic move_t tok_move(token_t t);
        return '{ACT_TOKEN, t, PFX_NONE};
    endfunction

    function automatic move_t go_move(prefix_t p);
        return '{ACT_GO, TK_NL, p};
    endfunction

    function automatic token_t flush_token(prefix_t s);
        token_t t;
        case (s)
            PFX_EQ:        t = TK_ASSIGN;
            PFX_SLASH:     t = TK_SLASH;
            PFX_PCT:       t = TK_PCT;
            PFX_BANG:      t = TK_BANG;
            PFX_DOT:       t = TK_DOT;
            PFX_DOT2:      t = TK_DOT2;
            PFX_AMP:       t = TK_AMP;
            PFX_BAR:       t = TK_BAR;
            PFX_PLUS:      t = TK_PLUS;
            PFX_PLUS_PCT:  t = TK_PLUS_PCT;
            PFX_PLUS_BAR:  t = TK_PLUS_BAR;
            PFX_MINUS:     t = TK_MINUS;
            PFX_MINUS_PCT: t = TK_MINUS_PCT;
            PFX_MINUS_BAR: t = TK_MINUS_BAR;
            PFX_STAR:      t = TK_STAR;
            PFX_STAR_PCT:  t = TK_STAR_PCT;
            PFX_STAR_BAR:  t = TK_STAR_BAR;
            PFX_LT:        t = TK_LT;
            PFX_LT2:       t = TK_SHL;
            PFX_LT2_BAR:   t = TK_SHL_BAR;
            PFX_GT:        t = TK_GT;
            PFX_GT2:       t = TK_SHR;
            PFX_GT2_BAR:   t = TK_SHR_BAR;
            default:       t = TK_NL;
        endcase
        return t;
    endfunction

    function automatic move_t extend_move(prefix_t s, logic [7:0] b);
        move_t m;
        m = MISS_MOVE;
        case (s)
            PFX_EQ:        m = (b == "=") ? tok_move(TK_EQ) : MISS_MOVE;
            PFX_SLASH:     m = (b == "=") ? tok_move(TK_SLASH_EQ) : MISS_MOVE;
            PFX_PCT:       m = (b == "=") ? tok_move(TK_PCT_EQ) : MISS_MOVE;
            PFX_BANG:      m = (b == "=") ? tok_move(TK_NE) : MISS_MOVE;
            PFX_DOT:       m = (b == ".") ? go_move(PFX_DOT2) : MISS_MOVE;
            PFX_DOT2:      m = (b == "=") ? tok_move(TK_DOT2_EQ) : MISS_MOVE;
            PFX_AMP:       m = (b == "=") ? tok_move(TK_AMP_EQ)
                             : (b == "&") ? tok_move(TK_AMP2) : MISS_MOVE;
            PFX_BAR:       m = (b == "=") ? tok_move(TK_BAR_EQ)
                             : (b == "|") ? tok_move(TK_BAR2) : MISS_MOVE;
            PFX_PLUS:      m = (b == "=") ? tok_move(TK_PLUS_EQ)
                             : (b == "%") ? go_move(PFX_PLUS_PCT)
                             : (b == "|") ? go_move(PFX_PLUS_BAR) : MISS_MOVE;
            PFX_PLUS_PCT:  m = (b == "=") ? tok_move(TK_PLUS_PCT_EQ) : MISS_MOVE;
            PFX_PLUS_BAR:  m = (b == "=") ? tok_move(TK_PLUS_BAR_EQ) : MISS_MOVE;
            PFX_MINUS:     m = (b == "=") ? tok_move(TK_MINUS_EQ)
                             : (b == "%") ? go_move(PFX_MINUS_PCT)
                             : (b == "|") ? go_move(PFX_MINUS_BAR) : MISS_MOVE;
            PFX_MINUS_PCT: m = (b == "=") ? tok_move(TK_MINUS_PCT_EQ) : MISS_MOVE;
            PFX_MINUS_BAR: m = (b == "=") ? tok_move(TK_MINUS_BAR_EQ) : MISS_MOVE;
            PFX_STAR:      m = (b == "=") ? tok_move(TK_STAR_EQ)
                             : (b == "%") ? go_move(PFX_STAR_PCT)
                             : (b == "|") ? go_move(PFX_STAR_BAR) : MISS_MOVE;
            PFX_STAR_PCT:  m = (b == "=") ? tok_move(TK_STAR_PCT_EQ) : MISS_MOVE;
            PFX_STAR_BAR:  m = (b == "=") ? tok_move(TK_STAR_BAR_EQ) : MISS_MOVE;
            PFX_LT:        m = (b == "=") ? tok_move(TK_LE)
                             : (b == "<") ? go_move(PFX_LT2) : MISS_MOVE;
            PFX_LT2:       m = (b == "=") ? tok_move(TK_SHL_EQ)
                             : (b == "|") ? go_move(PFX_LT2_BAR) : MISS_MOVE;
            PFX_LT2_BAR:   m = (b == "=") ? tok_move(TK_SHL_BAR_EQ) : MISS_MOVE;
            PFX_GT:        m = (b == "=") ? tok_move(TK_GE)
                             : (b == ">") ? go_move(PFX_GT2) : MISS_MOVE;
            PFX_GT2:       m = (b == "=") ? tok_move(TK_SHR_EQ)
                             : (b == "|") ? go_move(PFX_GT2_BAR) : MISS_MOVE;
            PFX_GT2_BAR:   m = (b == "=") ? tok_move(TK_SHR_BAR_EQ) : MISS_MOVE;
            default:       m = MISS_MOVE;
        endcase
        return m;
    endfunction

    function automatic move_t start_move(logic [7:0] b);
        move_t m;
        case (b)
            "\n":    m = tok_move(TK_NL);
            "(":     m = tok_move(TK_LPAREN);
            ")":     m = tok_move(TK_RPAREN);
            "[":     m = tok_move(TK_LBRACK);
            "]":     m = tok_move(TK_RBRACK);
            "{":     m = tok_move(TK_LBRACE);
            "}":     m = tok_move(TK_RBRACE);
            "~":     m = tok_move(TK_TILDE);
            "@":     m = tok_move(TK_AT);
            "$":     m = tok_move(TK_DOLLAR);
            ",":     m = tok_move(TK_COMMA);
            ";":     m = tok_move(TK_SEMI);
            ":":     m = tok_move(TK_COLON);
            "=":     m = go_move(PFX_EQ);
            "/":     m = go_move(PFX_SLASH);
            "%":     m = go_move(PFX_PCT);
            "!":     m = go_move(PFX_BANG);
            ".":     m = go_move(PFX_DOT);
            "&":     m = go_move(PFX_AMP);
            "|":     m = go_move(PFX_BAR);
            "+":     m = go_move(PFX_PLUS);
            "-":     m = go_move(PFX_MINUS);
            "*":     m = go_move(PFX_STAR);
            "<":     m = go_move(PFX_LT);
            ">":     m = go_move(PFX_GT);
            " ":     m = SKIP_MOVE;
            "\t":    m = SKIP_MOVE;
            default: m = MISS_MOVE;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/operator_token_scanner.sv =====
// ----------------------------------------------------------------------------
// Operator token scanner
// Longest-match operator tokeniser over a byte stream, with start offsets.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_stall    source_byte, end_of_input
//  output   out_valid / out_stall  token_code, bad_byte, start_offset, last_result
//
// One input beat is taken per cycle while the result queue has room; a beat
// that gives two results is delivered as two output beats. Each input beat
// is registered before it is resolved, and its results pass through the result
// queue. Reset clears the pending prefix, the offsets and the queue. in_stall
// is raised only while a held input beat waits on a full result queue.
// ----------------------------------------------------------------------------
module operator_token_scanner
    import ots_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             source_byte,
    input  logic                   end_of_input,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             token_code,
    output logic                   bad_byte,
    output logic [START_WIDTH-1:0] start_offset,
    output logic                   last_result
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    prefix_t    prefix_reg;
    prefix_t    prefix_next;
    offset_t    offset_reg;
    offset_t    offset_next;
    offset_t    start_reg;
    offset_t    start_next;
    record_t    step_rec;
    logic       fifo_full;
    logic       advance;
    logic       load;
    result_t    cur;

    assign in_stall = in_valid_reg & fifo_full;
    assign advance  = in_valid_reg & ~fifo_full;
    assign load     = in_valid & ~in_stall;

    ots_step u_step (
        .prefix       (prefix_reg),
        .offset       (offset_reg),
        .token_start  (start_reg),
        .source_byte  (byte_reg),
        .end_of_input (end_reg),
        .rec          (step_rec),
        .next_prefix  (prefix_next),
        .next_offset  (offset_next),
        .next_start   (start_next)
    );

    ots_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && (step_rec.count != 2'd0)),
        .push_rec  (step_rec),
        .out_stall (out_stall),
        .full      (fifo_full),
        .out_valid (out_valid),
        .cur       (cur),
        .last      (last_result)
    );

    assign token_code   = cur.code;
    assign bad_byte     = cur.bad;
    assign start_offset = cur.at;

    always_comb
    begin
        in_valid_next = load | (in_valid_reg & ~advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            prefix_reg   <= PFX_NONE;
            offset_reg   <= '0;
            start_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                prefix_reg <= prefix_next;
                offset_reg <= offset_next;
                start_reg  <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= source_byte;
            end_reg  <= end_of_input;
        end
    end

`include "operator_token_scanner_assert.svh"

    `OTS_ASSERT_NOW(a_bad_code_zero, out_valid && bad_byte, token_code == TK_NL,
        "bad byte result carries a non-zero token code")
    `OTS_ASSERT_NOW(a_bad_is_last, out_valid && bad_byte, last_result,
        "bad byte result is not the last result of its beat")
    `OTS_ASSERT_NEXT(a_end_clears, advance && end_reg, prefix_reg == PFX_NONE,
        "end marker left a prefix pending")

endmodule

// ===== hw/rtl/ots_step.sv =====
// ----------------------------------------------------------------------------
// Operator token scanner step logic
// Resolves one beat against the pending prefix into up to two results.
// ----------------------------------------------------------------------------
module ots_step
    import ots_pkg::*;
(
    input  prefix_t    prefix,
    input  offset_t    offset,
    input  offset_t    token_start,
    input  logic [7:0] source_byte,
    input  logic       end_of_input,
    output record_t    rec,
    output prefix_t    next_prefix,
    output offset_t    next_offset,
    output offset_t    next_start
);

    move_t                  ext_mv;
    move_t                  fresh_mv;
    result_t                fresh_res;
    logic                   fresh;
    logic                   fresh_put;
    logic [START_WIDTH-1:0] here;
    logic [START_WIDTH-1:0] held;

    assign here = START_WIDTH'(offset);
    assign held = START_WIDTH'(token_start);

    always_comb
    begin
        ext_mv      = extend_move(prefix, source_byte);
        fresh_mv    = start_move(source_byte);
        rec         = '0;
        next_prefix = prefix;
        next_offset = offset;
        next_start  = token_start;
        fresh       = 1'b0;
        fresh_put   = 1'b0;
        fresh_res   = '{fresh_mv.tok, 1'b0, here};

        if (end_of_input)
        begin
            if (prefix != PFX_NONE)
            begin
                rec.count = 2'd1;
                rec.first = '{flush_token(prefix), 1'b0, held};
            end
            next_prefix = PFX_NONE;
        end
        else
        begin
            fresh       = 1'b1;
            next_offset = offset + offset_t'(1);
            if (prefix != PFX_NONE)
            begin
                case (ext_mv.act)
                    ACT_GO:
                    begin
                        next_prefix = ext_mv.pfx;
                        fresh       = 1'b0;
                    end
                    ACT_TOKEN:
                    begin
                        rec.count   = 2'd1;
                        rec.first   = '{ext_mv.tok, 1'b0, held};
                        next_prefix = PFX_NONE;
                        fresh       = 1'b0;
                    end
                    default:
                    begin
                        rec.count   = 2'd1;
                        rec.first   = '{flush_token(prefix), 1'b0, held};
                        next_prefix = PFX_NONE;
                    end
                endcase
            end
        end

        if (fresh)
        begin
            case (fresh_mv.act)
                ACT_GO:
                begin
                    next_prefix = fresh_mv.pfx;
                    next_start  = offset;
                end
                ACT_TOKEN:
                begin
                    fresh_put = 1'b1;
                end
                ACT_MISS:
                begin
                    fresh_put = 1'b1;
                    fresh_res = '{TK_NL, 1'b1, here};
                end
                default:
                begin
                    fresh_put = 1'b0;
                end
            endcase
        end

        if (fresh_put)
        begin
            if (rec.count == 2'd0)
            begin
                rec.count = 2'd1;
                rec.first = fresh_res;
            end
            else
            begin
                rec.count  = 2'd2;
                rec.second = fresh_res;
            end
        end
    end

endmodule

// ===== hw/rtl/ots_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Operator token scanner result queue
// Two-entry queue of per-beat records, delivered one result per output beat.
// ----------------------------------------------------------------------------
module ots_result_fifo
    import ots_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    input  logic    out_stall,
    output logic    full,
    output logic    out_valid,
    output result_t cur,
    output logic    last
);

    record_t    rec_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       sel_reg;
    logic       sel_next;
    record_t    head;
    logic       beat;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = rec_reg[rd_ptr_reg];
    assign cur       = sel_reg ? head.second : head.first;
    assign last      = sel_reg | (head.count == 2'd1);
    assign beat      = out_valid & ~out_stall;
    assign pop       = beat & last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
        sel_next    = beat ? ~last : sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
